### design/sket_pkg.sv
package sket_pkg;

  // Operation codes carried on func
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BAD_RANGE = 3'd5;

  localparam int KEY_W   = 31;
  localparam int POS_W   = 6;
  localparam int USAGE_SHIFT = 16;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [31:0]       usage;
    logic signed [31:0] value;
    logic signed [31:0] lmin;
    logic signed [31:0] lmax;
  } entry_t;

endpackage

### design/sorted_key_entry_table_unit.sv
// Channel | Direction | Handshake            | Word
// --------+-----------+----------------------+-----------------------------------------
// in      | input     | in_valid / in_ready  | func, key, usage_page, usage_code,
//         |           |                      | current_value, logical_min, logical_max
// out     | output    | out_valid / out_ready| status, position, usage_word,
//         |           |                      | entry_value, entry_min, entry_max
//
// One word is worked at a time. A bad range goes straight to the result. A lookup
// runs S probes (at most clog2(TABLE_DEPTH)+1), each a read plus a compare; a miss
// takes one more, final empty probe. An insert adds to the miss path a shift of the
// entries from position up, one entry per cycle, and one write of the new entry.
// Reset clears the entry count and the handshake; memory contents need no clear.
// A new input word is taken while a finished result waits on the output.
module sorted_key_entry_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [30:0]        key,
  input  logic [15:0]        usage_page,
  input  logic [15:0]        usage_code,
  input  logic signed [31:0] current_value,
  input  logic signed [31:0] logical_min,
  input  logic signed [31:0] logical_max,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [5:0]         position,
  output logic [31:0]        usage_word,
  output logic signed [31:0] entry_value,
  output logic signed [31:0] entry_min,
  output logic signed [31:0] entry_max
);
  import sket_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PROBE = 6'b000010,
    S_CMP   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Entry memory and its ports
  entry_t          ent_mem [TABLE_DEPTH];
  entry_t          rd_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  // Search and shift control
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hi;
  logic [CW-1:0]   mid;
  logic [CW-1:0]   cur;
  logic            pend;
  logic [AW-1:0]   pend_addr;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid_next;
  logic [CW+5:0]   lo_ext;
  logic [CW+5:0]   mid_ext;

  // Accepted word
  logic            item_func;
  entry_t          item_ent;

  // Staged result
  logic [2:0]      res_status;
  logic [5:0]      res_pos;
  logic [31:0]     res_usage;
  logic [31:0]     res_value;
  logic [31:0]     res_min;
  logic [31:0]     res_max;

  logic            in_fire;
  logic            out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_next = mid_sum[CW:1];
  assign lo_ext   = {6'b0, lo};
  assign mid_ext  = {6'b0, mid};

  // Drive the memory ports from the sequencer state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_next[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    unique case (state)
      S_PROBE: begin
        rd_en   = (lo < hi);
        rd_addr = mid_next[AW-1:0];
      end
      S_SHIFT: begin
        rd_en   = (cur > lo);
        rd_addr = AW'(cur - CW'(1));
        wr_en   = pend;
        wr_addr = pend_addr;
        wr_data = rd_data;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = lo[AW-1:0];
        wr_data = item_ent;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // Write the entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
  end

  // Read the entry memory into a registered read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ent_mem[rd_addr];
    end
  end

  // Sequence search, shift and insert
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      pend        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            item_func      <= func;
            item_ent.key   <= key;
            item_ent.usage <= ({16'b0, usage_page} << USAGE_SHIFT) | {16'b0, usage_code};
            item_ent.value <= current_value;
            item_ent.lmin  <= logical_min;
            item_ent.lmax  <= logical_max;
            lo             <= '0;
            hi             <= (entry_count > DEPTH_C) ? DEPTH_C : entry_count;
            res_usage      <= '0;
            res_value      <= '0;
            res_min        <= '0;
            res_max        <= '0;
            if (func == FUNC_INSERT && logical_min >= logical_max) begin
              res_status <= ST_BAD_RANGE;
              res_pos    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CMP;
          end else begin
            res_pos <= lo_ext[5:0];
            if (item_func == FUNC_LOOKUP) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else if (entry_count >= DEPTH_C) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              cur   <= entry_count;
              pend  <= 1'b0;
              state <= S_SHIFT;
            end
          end
        end
        S_CMP: begin
          priority if (item_ent.key < rd_data.key) begin
            hi    <= mid;
            state <= S_PROBE;
          end else if (item_ent.key > rd_data.key) begin
            lo    <= mid + CW'(1);
            state <= S_PROBE;
          end else begin
            res_pos <= mid_ext[5:0];
            if (item_func == FUNC_LOOKUP) begin
              res_status <= ST_FOUND;
              res_usage  <= rd_data.usage;
              res_value  <= rd_data.value;
              res_min    <= rd_data.lmin;
              res_max    <= rd_data.lmax;
            end else begin
              res_status <= ST_DUPLICATE;
            end
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          // move entry cur-1 up to cur, one per cycle
          if (cur > lo) begin
            pend_addr <= cur[AW-1:0];
            pend      <= 1'b1;
            cur       <= cur - CW'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          entry_count <= entry_count + CW'(1);
          res_status  <= ST_INSERTED;
          res_pos     <= lo_ext[5:0];
          res_usage   <= item_ent.usage;
          res_value   <= item_ent.value;
          res_min     <= item_ent.lmin;
          res_max     <= item_ent.lmax;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      position    <= res_pos;
      usage_word  <= res_usage;
      entry_value <= res_value;
      entry_min   <= res_min;
      entry_max   <= res_max;
    end
  end

  // Count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count above table depth");

  // No memory write outside shift and insert
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_PROBE || state == S_CMP || state == S_DONE) |-> !wr_en)
    else $error("memory write outside shift or insert");

  // Shift writes land above the insertion point
  a_shift_above: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend) |-> ({1'b0, pend_addr} > lo))
    else $error("shift write at or below insertion point");

  // Insert bumps the count by exactly one
  a_put_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> (entry_count == $past(entry_count) + CW'(1)))
    else $error("insert did not advance entry count");

endmodule
